// ===== hdl/msrq_pkg.sv =====
// Shared types and constants for the message slot ring queue.
// Operation codes, register indexes, result word and the byte mask helper.
// No dependencies.
package msrq_pkg;

  localparam int MSG_W = 64;
  localparam logic [3:0] SLOT_MAX_BYTES = 4'd8;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_PUT_RENEW = 2'd1,
    OP_GET       = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_SLOT_COUNT = 2'd0,
    CFG_SLOT_BYTES = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic             ok;
    logic [MSG_W-1:0] msg;
    logic [3:0]       used;
    logic [3:0]       free_cnt;
  } res_t;

  function automatic logic [MSG_W-1:0] byte_mask(input logic [3:0] n);
    logic [MSG_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== hdl/message_slot_ring_queue_core.sv =====
// Message slot ring queue, top level: slot store, controller, result register.
// Depends on msrq_pkg, msrq_slot_ram and msrq_ctrl.

// Each accepted word goes through a read step and a write step: first the
// addressed slot is read from the single-port-read slot store, then the bytes
// are merged or extracted, the slot is written back and the result register is
// loaded. in_stall stays high until the write step is done, so no new word is
// taken before the last one is through. The write step waits while the result
// register is still full and stalled. After reset the slot store is zeroed one
// entry per cycle, with in_stall held high until the sweep is done; config writes are taken throughout.
module message_slot_ring_queue_core
  import msrq_pkg::*;
#(
  parameter int SLOT_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [4:0]       cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [3:0]       in_num_bytes,
  input  logic [MSG_W-1:0] in_msg_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_ok,
  output logic [MSG_W-1:0] out_msg_out,
  output logic [3:0]       out_used_count,
  output logic [3:0]       out_free_count
);

  localparam int IW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  logic             ram_we, ram_re, res_load, out_free;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [MSG_W-1:0] ram_wdata, ram_rdata;
  res_t             res;
  logic             out_valid_r;
  res_t             out_r;

  msrq_slot_ram #(
    .DEPTH (SLOT_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  msrq_ctrl #(
    .SLOT_DEPTH (SLOT_DEPTH),
    .IW         (IW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_op        (in_op),
    .in_num_bytes (in_num_bytes),
    .in_msg_in    (in_msg_in),
    .in_stall     (in_stall),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_r.ok;
  assign out_msg_out    = out_r.msg;
  assign out_used_count = out_r.used;
  assign out_free_count = out_r.free_cnt;

endmodule

// ===== hdl/msrq_slot_ram.sv =====
// Slot store: single write port, single read port, registered read data.
// Uses msrq_pkg for the word width.
module msrq_slot_ram
  import msrq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [MSG_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [MSG_W-1:0] rdata
);

  logic [MSG_W-1:0] mem [DEPTH];
  logic [MSG_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/msrq_ctrl.sv =====
// Queue controller: config registers, ring indices, clearing sweep and the
// read-merge-write sequence on the slot store. Uses msrq_pkg.
module msrq_ctrl
  import msrq_pkg::*;
#(
  parameter int SLOT_DEPTH = 16,
  parameter int IW         = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [4:0]       cfg_wdata,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  input  logic [3:0]       in_num_bytes,
  input  logic [MSG_W-1:0] in_msg_in,
  output logic             in_stall,
  input  logic             out_free,
  output logic             res_load,
  output res_t             res,
  output logic             ram_we,
  output logic [IW-1:0]    ram_waddr,
  output logic [MSG_W-1:0] ram_wdata,
  output logic             ram_re,
  output logic [IW-1:0]    ram_raddr,
  input  logic [MSG_W-1:0] ram_rdata
);

  localparam int CW = ((IW > 5) ? IW : 5) + 1;

  state_t           state_r, state_nxt;
  logic [IW-1:0]    clr_addr_r;
  logic [IW-1:0]    rd_idx_r, wr_idx_r;
  logic [4:0]       slot_count_r;
  logic [3:0]       slot_bytes_r;
  op_t              op_r;
  logic [3:0]       num_r;
  logic [MSG_W-1:0] msg_r;

  logic [4:0]       eff_cnt;
  logic [3:0]       eff_bytes;
  logic [CW-1:0]    cnt_w, rd_w, wr_w, rd_nx, wr_nx, rd_new, wr_new;
  logic [CW-1:0]    used_pre, free_pre, used_post, free_post;
  logic [MSG_W-1:0] mask, merged, rd_msg;
  logic             len_ok, ok, wr_slot, accept, clr_last;

  function automatic logic [CW-1:0] used_of(input logic [CW-1:0] r, input logic [CW-1:0] w,
                                            input logic [CW-1:0] c);
    if (w >= r) begin
      return w - r;
    end
    return c - r + w;
  endfunction

  function automatic logic [CW-1:0] next_of(input logic [CW-1:0] i, input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = i + CW'(1);
    return (n >= c) ? '0 : n;
  endfunction

  // effective register values
  always_comb begin
    if (slot_count_r < 5'd2) begin
      eff_cnt = 5'd2;
    end else if (32'(slot_count_r) > SLOT_DEPTH) begin
      eff_cnt = 5'(SLOT_DEPTH);
    end else begin
      eff_cnt = slot_count_r;
    end
    if (slot_bytes_r == 4'd0) begin
      eff_bytes = 4'd1;
    end else if (slot_bytes_r > SLOT_MAX_BYTES) begin
      eff_bytes = SLOT_MAX_BYTES;
    end else begin
      eff_bytes = slot_bytes_r;
    end
  end

  // operation datapath, evaluated while the slot read data is present
  always_comb begin
    cnt_w    = CW'(eff_cnt);
    rd_w     = CW'(rd_idx_r);
    wr_w     = CW'(wr_idx_r);
    rd_nx    = next_of(rd_w, cnt_w);
    wr_nx    = next_of(wr_w, cnt_w);
    used_pre = used_of(rd_w, wr_w, cnt_w);
    free_pre = cnt_w - used_pre - CW'(1);
    len_ok   = (num_r <= eff_bytes);
    mask     = byte_mask(num_r);
    merged   = (ram_rdata & ~mask) | (msg_r & mask);
    ok       = 1'b0;
    rd_msg   = '0;
    rd_new   = rd_w;
    wr_new   = wr_w;
    wr_slot  = 1'b0;
    unique case (op_r)
      OP_CLEAR: begin
        rd_new = wr_w;
        ok     = 1'b1;
      end
      OP_GET: begin
        if (len_ok && (used_pre != '0)) begin
          ok     = 1'b1;
          rd_msg = ram_rdata & mask;
          rd_new = rd_nx;
        end
      end
      OP_PUT, OP_PUT_RENEW: begin
        if (len_ok && ((free_pre != '0) || (op_r == OP_PUT_RENEW))) begin
          ok      = 1'b1;
          wr_slot = 1'b1;
          wr_new  = wr_nx;
          if (free_pre == '0) begin
            rd_new = rd_nx;
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    used_post = used_of(rd_new, wr_new, cnt_w);
    free_post = cnt_w - used_post - CW'(1);
  end

  assign clr_last = (clr_addr_r == IW'(SLOT_DEPTH - 1));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = (op_t'(in_op) == OP_GET) ? rd_idx_r : wr_idx_r;
    ram_we    = 1'b0;
    ram_waddr = wr_idx_r;
    ram_wdata = merged;
    res_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_re   = in_valid;
      end
      ST_EXEC: begin
        res_load = out_free;
        ram_we   = out_free && wr_slot;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign res.ok       = ok;
  assign res.msg      = rd_msg;
  assign res.used     = used_post[3:0];
  assign res.free_cnt = free_post[3:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
      slot_count_r <= 5'd16;
      slot_bytes_r <= 4'd8;
      op_r         <= OP_PUT;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + IW'(1);
      end
      if (accept) begin
        op_r <= op_t'(in_op);
      end
      if (cfg_we && (cfg_reg_t'(cfg_index) == CFG_SLOT_COUNT)) begin
        slot_count_r <= cfg_wdata;
        rd_idx_r     <= '0;
        wr_idx_r     <= '0;
      end else if (res_load) begin
        rd_idx_r <= IW'(rd_new);
        wr_idx_r <= IW'(wr_new);
      end
      if (cfg_we && (cfg_reg_t'(cfg_index) == CFG_SLOT_BYTES)) begin
        slot_bytes_r <= cfg_wdata[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      num_r <= in_num_bytes;
      msg_r <= in_msg_in;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(rd_idx_r) < cnt_w) && (CW'(wr_idx_r) < cnt_w))
    else $error("ring index outside active slots");

  a_fail_keeps_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && !res.ok) |=> ($stable(rd_idx_r) && $stable(wr_idx_r)))
    else $error("rejected word moved an index");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> ((used_post + free_post) == (cnt_w - CW'(1))))
    else $error("used and free counts disagree with ring size");

  a_no_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("slot store written while idle");
`endif

endmodule
